/* src/bp2rgb_pkg.sv */
package bp2rgb_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] REG_COLOUR_RULE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANES      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DEPTH       = 2'd2;

   localparam logic [4:0] PLANES_RESET = 5'd8;
   localparam logic [3:0] DEPTH_RESET  = 4'd1;
   localparam logic [3:0] DEPTH_MAX    = 4'd8;

   // item opcodes
   localparam logic OP_PLANE   = 1'b0;
   localparam logic OP_PALETTE = 1'b1;

   // colour rules
   localparam logic RULE_PALETTE = 1'b0;
   localparam logic RULE_DEPTH   = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic [7:0] plane_byte;
      logic [7:0] entry_index;
      logic [7:0] entry_red;
      logic [7:0] entry_green;
      logic [7:0] entry_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [2:0] pixel_slot;
      logic       last_pixel;
   } rsp_type;

   // palette write carried through the queue
   typedef struct packed {
      logic [7:0] index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pal_wr_type;

   // settings seen by the back end, already clamped
   typedef struct packed {
      logic       colour_rule;
      logic [3:0] depth;
   } cfg_type;

endpackage

/* src/bitplane_to_rgb_pixels_core.sv */
// Bit-plane to RGB pixel converter.
//
// req channel: one item per accept. opcode OP_PLANE carries the next plane
// byte (plane 0 first); opcode OP_PALETTE writes one palette entry. After the
// configured number of plane bytes the block returns 8 pixel items on rsp,
// slot 0 (bit 0 of each plane byte) first, last_pixel set on slot 7.
// csr channel: csr_ready is always high; write only while the block is idle.
//
// Timing: with the back end idle, the last plane byte of a group passes the
// queue, the back end load, the palette read / channel scaling and the
// output register before rsp_valid rises. The back end then issues one pixel
// per cycle while stage 1 can advance, and pops nothing until slot 7 issues.
// Plane bytes that do not complete a group are taken every cycle while the queue has room.
// A two-entry queue separates the front (plane store, counter) from the
// back; req_ready drops only when that queue is full.
// When rsp_ready is low the output register and stage 1 hold their pixels,
// the back end stops, then the queue fills and req_ready falls.
// Reset clears the plane counter, queue and pipeline and restores
// colour_rule=0, planes_per_pixel=8, channel_depth=1. Palette contents are
// not cleared.
module bitplane_to_rgb_pixels_core #(
   parameter int MAX_PLANES   = 24,
   parameter int PALETTE_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  bp2rgb_pkg::req_type                    req_data,

   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output bp2rgb_pkg::rsp_type                    rsp_data,

   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bp2rgb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bp2rgb_pkg::CSR_DATA_W-1:0]      csr_data
);
   import bp2rgb_pkg::*;

   localparam int CW = $clog2(MAX_PLANES + 1);
   localparam int EW = 8 * MAX_PLANES + $bits(pal_wr_type) + 1;

   // configuration registers
   logic       colour_rule_ff, colour_rule_in;
   logic [4:0] planes_ff, planes_in;
   logic [3:0] depth_ff, depth_in;
   logic       csr_write;

   // clamped settings
   logic [CW-1:0] planes_eff;
   cfg_type       cfg;

   // front / back coupling
   logic          req_accept;
   logic          q_push;
   logic [EW-1:0] q_push_data;
   logic          q_pop;
   logic          q_head_valid;
   logic [EW-1:0] q_head_data;
   logic          q_full;

   always_comb begin
      csr_write      = csr_valid && csr_ready;
      colour_rule_in = colour_rule_ff;
      planes_in      = planes_ff;
      depth_in       = depth_ff;
      if (csr_write) begin
         case (csr_index)
            REG_COLOUR_RULE: colour_rule_in = csr_data[0];
            REG_PLANES:      planes_in      = csr_data[4:0];
            REG_DEPTH:       depth_in       = csr_data[3:0];
            default:         ;  // unmapped index, write dropped
         endcase
      end

      // plane count: zero acts as one, anything above the store size as the store size
      if (planes_ff == 5'd0) begin
         planes_eff = CW'(1);
      end else if (planes_ff > 5'(MAX_PLANES)) begin
         planes_eff = CW'(MAX_PLANES);
      end else begin
         planes_eff = CW'(planes_ff);
      end

      cfg.colour_rule = colour_rule_ff;
      if (depth_ff == 4'd0) begin
         cfg.depth = 4'd1;
      end else if (depth_ff > DEPTH_MAX) begin
         cfg.depth = DEPTH_MAX;
      end else begin
         cfg.depth = depth_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colour_rule_ff <= RULE_PALETTE;
         planes_ff      <= PLANES_RESET;
         depth_ff       <= DEPTH_RESET;
      end else begin
         colour_rule_ff <= colour_rule_in;
         planes_ff      <= planes_in;
         depth_ff       <= depth_in;
      end
   end

   assign csr_ready  = 1'b1;
   assign req_ready  = !q_full;
   assign req_accept = req_valid && req_ready;

   bp2rgb_front #(
      .MAX_PLANES (MAX_PLANES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .req_data  (req_data),
      .planes    (planes_eff),
      .push      (q_push),
      .push_data (q_push_data)
   );

   bp2rgb_queue #(
      .WIDTH (EW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data),
      .full       (q_full)
   );

   bp2rgb_back #(
      .MAX_PLANES   (MAX_PLANES),
      .PALETTE_BITS (PALETTE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (q_head_valid),
      .head_data  (q_head_data),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

/* src/bp2rgb_ram.sv */
module bp2rgb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/bp2rgb_queue.sv */
module bp2rgb_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data,
   output logic             full
);

   // two-entry ring
   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign full       = (count_ff == 2'd2);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue underflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count corrupt");

endmodule

/* src/bp2rgb_front.sv */
module bp2rgb_front #(
   parameter int MAX_PLANES = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  bp2rgb_pkg::req_type                   req_data,
   input  logic [$clog2(MAX_PLANES+1)-1:0]       planes,
   output logic                                  push,
   output logic [8*MAX_PLANES+$bits(bp2rgb_pkg::pal_wr_type):0] push_data
);
   import bp2rgb_pkg::*;

   localparam int CW = $clog2(MAX_PLANES + 1);

   logic [7:0]          store_ff [MAX_PLANES];
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       idx;
   logic [CW-1:0]       next_cnt;
   logic                is_plane;
   logic                group_done;
   logic [7:0]          cur_byte;
   logic [MAX_PLANES-1:0] vals [8];
   logic [8*MAX_PLANES-1:0] vals_flat;
   pal_wr_type          pal_wr;

   always_comb begin
      is_plane   = (req_data.opcode == OP_PLANE);
      idx        = (cnt_ff >= CW'(MAX_PLANES)) ? '0 : cnt_ff;
      next_cnt   = idx + CW'(1);
      group_done = (next_cnt >= planes);

      cnt_in = cnt_ff;
      if (accept && is_plane) begin
         cnt_in = group_done ? '0 : next_cnt;
      end

      // transpose: bit p of pixel j is bit j of plane p, planes past the count read zero
      for (int j = 0; j < 8; j++) begin
         for (int p = 0; p < MAX_PLANES; p++) begin
            cur_byte   = (CW'(p) == idx) ? req_data.plane_byte : store_ff[p];
            vals[j][p] = (CW'(p) < planes) && cur_byte[j];
         end
         vals_flat[j*MAX_PLANES +: MAX_PLANES] = vals[j];
      end

      pal_wr.index = req_data.entry_index;
      pal_wr.red   = req_data.entry_red;
      pal_wr.green = req_data.entry_green;
      pal_wr.blue  = req_data.entry_blue;

      push      = accept && (!is_plane || group_done);
      push_data = {vals_flat, pal_wr, !is_plane};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < MAX_PLANES; p++) begin
         if (accept && is_plane && CW'(p) == idx) begin
            store_ff[p] <= req_data.plane_byte;
         end
      end
   end

endmodule

/* src/bp2rgb_back.sv */
module bp2rgb_back #(
   parameter int MAX_PLANES   = 24,
   parameter int PALETTE_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  bp2rgb_pkg::cfg_type cfg,
   input  logic                head_valid,
   input  logic [8*MAX_PLANES+$bits(bp2rgb_pkg::pal_wr_type):0] head_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bp2rgb_pkg::rsp_type rsp_data
);
   import bp2rgb_pkg::*;

   localparam int PW = $bits(pal_wr_type);

   // c*255/(2^d-1) == (c * 255*ceil(2^24/(2^d-1))) >> 24, exact for c*255 < 2^16
   localparam logic [31:0] SCALE_D1 = 32'(64'd255 * ((64'd16777216 + 64'd0) / 64'd1));
   localparam logic [31:0] SCALE_D2 = 32'(64'd255 * ((64'd16777216 + 64'd2) / 64'd3));
   localparam logic [31:0] SCALE_D3 = 32'(64'd255 * ((64'd16777216 + 64'd6) / 64'd7));
   localparam logic [31:0] SCALE_D4 = 32'(64'd255 * ((64'd16777216 + 64'd14) / 64'd15));
   localparam logic [31:0] SCALE_D5 = 32'(64'd255 * ((64'd16777216 + 64'd30) / 64'd31));
   localparam logic [31:0] SCALE_D6 = 32'(64'd255 * ((64'd16777216 + 64'd62) / 64'd63));
   localparam logic [31:0] SCALE_D7 = 32'(64'd255 * ((64'd16777216 + 64'd126) / 64'd127));
   localparam logic [31:0] SCALE_D8 = 32'(64'd255 * ((64'd16777216 + 64'd254) / 64'd255));

   function automatic logic [7:0] pick_channel(input logic [MAX_PLANES-1:0] value,
                                               input int first,
                                               input logic [3:0] depth);
      logic [7:0] c;
      c = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < depth && (3 * i + first) < MAX_PLANES) begin
            c[i] = value[3 * i + first];
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] scale_channel(input logic [7:0] c, input logic [3:0] depth);
      logic [31:0] mul;
      logic [39:0] prod;
      case (depth)
         4'd1:    mul = SCALE_D1;
         4'd2:    mul = SCALE_D2;
         4'd3:    mul = SCALE_D3;
         4'd4:    mul = SCALE_D4;
         4'd5:    mul = SCALE_D5;
         4'd6:    mul = SCALE_D6;
         4'd7:    mul = SCALE_D7;
         default: mul = SCALE_D8;
      endcase
      prod = 40'(c) * 40'(mul);
      return prod[31:24];
   endfunction

   logic                  is_write;
   pal_wr_type            pal_wr;
   logic [MAX_PLANES-1:0] vals_ff [8];
   logic                  run_ff, run_in;
   logic [2:0]            slot_ff, slot_in;
   logic [MAX_PLANES-1:0] cur_value;
   logic                  issue;
   logic                  s1_adv;
   logic [23:0]           bd_rgb;

   // stage 1: palette read in flight or expanded colour
   logic                  s1_valid_ff, s1_valid_in;
   logic [2:0]            s1_slot_ff;
   logic                  s1_pal_ff;
   logic [23:0]           s1_rgb_ff;

   // output register
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff;

   logic                     wr_en;
   logic [PALETTE_BITS-1:0]  wr_addr;
   logic [23:0]              wr_data;
   logic                     rd_en;
   logic [PALETTE_BITS-1:0]  rd_addr;
   logic [23:0]              rd_data;

   always_comb begin
      is_write  = head_data[0];
      pal_wr    = head_data[PW:1];
      pop       = head_valid && !run_ff;

      wr_en     = pop && is_write;
      wr_addr   = PALETTE_BITS'(pal_wr.index);
      wr_data   = {pal_wr.red, pal_wr.green, pal_wr.blue};

      cur_value = vals_ff[slot_ff];
      s1_adv    = s1_valid_ff && (!out_valid_ff || rsp_ready);
      issue     = run_ff && (!s1_valid_ff || s1_adv);

      rd_en     = issue && (cfg.colour_rule == RULE_PALETTE);
      rd_addr   = PALETTE_BITS'(cur_value);

      bd_rgb = {scale_channel(pick_channel(cur_value, 0, cfg.depth), cfg.depth),
                scale_channel(pick_channel(cur_value, 1, cfg.depth), cfg.depth),
                scale_channel(pick_channel(cur_value, 2, cfg.depth), cfg.depth)};

      run_in  = run_ff;
      slot_in = slot_ff;
      if (pop && !is_write) begin
         run_in  = 1'b1;
         slot_in = 3'd0;
      end else if (issue) begin
         slot_in = slot_ff + 3'd1;
         if (slot_ff == 3'd7) begin
            run_in = 1'b0;
         end
      end

      s1_valid_in = issue || (s1_valid_ff && !s1_adv);
      out_valid_in = s1_adv || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         slot_ff      <= 3'd0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         slot_ff      <= slot_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && !is_write) begin
         for (int j = 0; j < 8; j++) begin
            vals_ff[j] <= head_data[PW + 1 + j*MAX_PLANES +: MAX_PLANES];
         end
      end
      if (issue) begin
         s1_slot_ff <= slot_ff;
         s1_pal_ff  <= (cfg.colour_rule == RULE_PALETTE);
         s1_rgb_ff  <= bd_rgb;
      end
      if (s1_adv) begin
         {out_ff.red, out_ff.green, out_ff.blue} <= s1_pal_ff ? rd_data : s1_rgb_ff;
         out_ff.pixel_slot <= s1_slot_ff;
         out_ff.last_pixel <= (s1_slot_ff == 3'd7);
      end
   end

   bp2rgb_ram #(
      .WIDTH (24),
      .DEPTH (2 ** PALETTE_BITS)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_slot_ff))
      else $error("stage 1 dropped a pixel under stall");

   a_group_ends: assert property (@(posedge clock) disable iff (reset)
      issue && slot_ff == 3'd7 |=> !run_ff)
      else $error("group ran past slot 7");

   a_ram_ports: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en)
      else $error("palette write during pixel lookup");

endmodule
